// File: rtl/core/rdvu_pkg.sv
// Shared constants, types and helper functions of the ring distance-vector update core.
package rdvu_pkg;

    localparam int RING_NODES = 16;
    localparam int IDX_W      = $clog2(RING_NODES);
    localparam int ROW_AW     = IDX_W + 1;
    localparam int ROW_DEPTH  = 2 * RING_NODES;
    localparam int EMIT_LEN   = (RING_NODES < 16) ? RING_NODES : 16;
    localparam int EK_W       = (EMIT_LEN > 1) ? $clog2(EMIT_LEN) : 1;
    localparam int NODE_W     = 4;
    localparam int DIST_W     = 8;
    localparam int ID_EXT_W   = 8;

    localparam logic [DIST_W-1:0] INF_DIST = 8'hFF;
    localparam logic [DIST_W-1:0] HOP_COST = 8'd1;
    localparam logic [DIST_W-1:0] SELF_DIST = 8'd0;

    localparam logic CMD_ELEMENT = 1'b0;
    localparam logic CMD_INIT    = 1'b1;

    typedef logic [ID_EXT_W-1:0] t_node_ext;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [ROW_AW-1:0]   t_row_addr;
    typedef logic [EK_W-1:0]     t_emit_cnt;
    typedef logic [NODE_W-1:0]   t_node;
    typedef logic [DIST_W-1:0]   t_dist;

    // Request bundle for the neighbor row memory.
    typedef struct packed {
        logic      clear;
        logic      we;
        t_row_addr waddr;
        t_dist     wdata;
        logic      re;
        t_row_addr raddr;
    } t_rows_req;

    // Request bundle for the own vector memory.
    typedef struct packed {
        logic  init;
        t_node init_id;
        logic  we;
        t_idx  waddr;
        t_dist wdata;
        logic  re;
        t_idx  raddr;
    } t_own_req;

    function automatic t_node_ext next_of(input t_node id);
        t_node_ext inc;
        inc = t_node_ext'(id) + t_node_ext'(1);
        return (inc >= t_node_ext'(RING_NODES)) ? '0 : inc;
    endfunction

    function automatic t_node_ext prev_of(input t_node id);
        return (id == '0) ? t_node_ext'(RING_NODES - 1) : t_node_ext'(id) - t_node_ext'(1);
    endfunction

    // Value an own vector entry takes right after initialization.
    function automatic t_dist init_value(input t_idx idx, input t_node id);
        t_node_ext ie;
        ie = t_node_ext'(idx);
        if (ie == next_of(id) || ie == prev_of(id)) begin
            return HOP_COST;
        end
        if (ie == t_node_ext'(id)) begin
            return SELF_DIST;
        end
        return INF_DIST;
    endfunction

endpackage

// File: rtl/core/rdvu_if.sv
// Valid/ready channel interfaces for neighbor words in and own vector words out.
interface rdvu_in_if;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    rdvu_pkg::t_node       source_node;
    rdvu_pkg::t_node       dest_index;
    rdvu_pkg::t_dist       distance;
    logic                  last_element;

    modport source (output valid, cmd, source_node, dest_index, distance, last_element,
                    input ready);
    modport sink   (input valid, cmd, source_node, dest_index, distance, last_element,
                    output ready);
endinterface

interface rdvu_out_if;
    logic                  valid;
    logic                  ready;
    rdvu_pkg::t_node       out_index;
    rdvu_pkg::t_dist       out_distance;
    logic                  out_last;

    modport source (output valid, out_index, out_distance, out_last, input ready);
    modport sink   (input valid, out_index, out_distance, out_last, output ready);
endinterface

// File: rtl/core/rdvu_rows_mem.sv
// Neighbor row memory with per-entry valid bits; an invalid entry reads as infinity.
module rdvu_rows_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rdvu_pkg::t_rows_req i_req,
    output rdvu_pkg::t_dist     o_rd_data
);

    rdvu_pkg::t_dist mem [rdvu_pkg::ROW_DEPTH];
    logic [rdvu_pkg::ROW_DEPTH-1:0] r_vld;
    rdvu_pkg::t_dist r_rd_data;
    logic            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_vld <= '0;
            end else if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_vld <= r_vld[i_req.raddr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : rdvu_pkg::INF_DIST;

endmodule

// File: rtl/core/rdvu_own_mem.sv
// Own distance vector memory; unwritten entries read as their initialization value.
module rdvu_own_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rdvu_pkg::t_own_req i_req,
    output rdvu_pkg::t_dist    o_rd_data
);

    rdvu_pkg::t_dist mem [rdvu_pkg::RING_NODES];
    logic [rdvu_pkg::RING_NODES-1:0] r_vld;
    logic            r_init_done;
    rdvu_pkg::t_node r_init_id;
    rdvu_pkg::t_dist r_rd_data;
    logic            r_rd_vld;
    rdvu_pkg::t_idx  r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= mem[i_req.raddr];
            r_rd_addr <= i_req.raddr;
        end
        if (i_req.init) begin
            r_init_id <= i_req.init_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_init_done <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (i_req.init) begin
                r_vld       <= '0;
                r_init_done <= 1'b1;
            end else if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_vld <= r_vld[i_req.raddr];
            end
        end
    end

    // Before any initialization every entry is unreachable.
    always_comb begin
        if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else if (r_init_done) begin
            o_rd_data = rdvu_pkg::init_value(r_rd_addr, r_init_id);
        end else begin
            o_rd_data = rdvu_pkg::INF_DIST;
        end
    end

endmodule

// File: rtl/core/ring_distance_vector_update_core.sv
// Top level of one ring node: neighbor words in, own distance vector words out.
// A neighbor element is read in IDLE, then modified and written back in UPD.
// An emitted vector reads each output word in ERD and offers it in EOUT, where any output stall holds it.
// A new neighbor element is taken only in IDLE, after the previous one leaves UPD; input is held off while emitting.
// Reset (synchronous, active low) clears both memories to infinity through valid bits,
// clears the changed flag and sets node_id to 0; no clearing pass is needed.
module ring_distance_vector_update_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  rdvu_pkg::t_node        i_cfg_data,
    rdvu_in_if.sink                i_in,
    rdvu_out_if.source             o_out
);

    // Sequencer states. IDLE takes a word, UPD finishes the read-modify-write,
    // ERD reads one own entry for emission and EOUT offers it downstream.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_ERD  = 4'b0100,
        S_EOUT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    rdvu_pkg::t_node     r_node_id;
    logic                r_changed, n_changed;
    rdvu_pkg::t_emit_cnt r_k, n_k;

    // Element fields held across the read cycle.
    rdvu_pkg::t_idx  r_dst;
    rdvu_pkg::t_dist r_dist;
    logic            r_last;
    logic            r_upd;

    rdvu_pkg::t_rows_req rows_req;
    rdvu_pkg::t_own_req  own_req;
    rdvu_pkg::t_dist     rows_rd;
    rdvu_pkg::t_dist     own_rd;

    logic            in_fire;
    logic            row_sel;
    logic            dst_ok;
    rdvu_pkg::t_idx  in_idx;
    rdvu_pkg::t_dist best;
    rdvu_pkg::t_dist new_dist;
    logic            moved;

    rdvu_rows_mem u_rows (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (rows_req),
        .o_rd_data (rows_rd)
    );

    rdvu_own_mem u_own (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (own_req),
        .o_rd_data (own_rd)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;

    // The element goes to row one when it comes from the next node, else row zero.
    assign row_sel = (rdvu_pkg::t_node_ext'(i_in.source_node) == rdvu_pkg::next_of(r_node_id));
    assign dst_ok  = (rdvu_pkg::t_node_ext'(i_in.dest_index)
                      < rdvu_pkg::t_node_ext'(rdvu_pkg::RING_NODES));
    assign in_idx  = rdvu_pkg::t_idx'(i_in.dest_index);

    // The row just written holds r_dist, so only the other row is read back.
    // Taking the smaller of the two and adding one hop, saturating at infinity.
    assign best     = (rows_rd < r_dist) ? rows_rd : r_dist;
    assign new_dist = (best == rdvu_pkg::INF_DIST) ? rdvu_pkg::INF_DIST
                                                   : best + rdvu_pkg::HOP_COST;
    assign moved    = r_upd && (own_rd != new_dist);

    always_comb begin
        n_state  = r_state;
        n_changed = r_changed;
        n_k      = r_k;
        rows_req = '0;
        own_req  = '0;
        own_req.init_id = r_node_id;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.cmd == rdvu_pkg::CMD_INIT) begin
                        // Initialization drops all stored rows and rebuilds the
                        // own vector, then announces it right away.
                        rows_req.clear = 1'b1;
                        own_req.init   = 1'b1;
                        n_changed      = 1'b0;
                        n_k            = '0;
                        n_state        = S_ERD;
                    end else begin
                        rows_req.we    = dst_ok;
                        rows_req.waddr = {row_sel, in_idx};
                        rows_req.wdata = i_in.distance;
                        rows_req.re    = dst_ok;
                        rows_req.raddr = {~row_sel, in_idx};
                        own_req.re     = dst_ok;
                        own_req.raddr  = in_idx;
                        n_state        = S_UPD;
                    end
                end
            end
            S_UPD: begin
                own_req.we    = moved;
                own_req.waddr = r_dst;
                own_req.wdata = new_dist;
                if (r_last && (r_changed || moved)) begin
                    n_changed = 1'b0;
                    n_k       = '0;
                    n_state   = S_ERD;
                end else begin
                    n_changed = r_changed || moved;
                    n_state   = S_IDLE;
                end
            end
            S_ERD: begin
                own_req.re    = 1'b1;
                own_req.raddr = rdvu_pkg::t_idx'(r_k);
                n_state       = S_EOUT;
            end
            S_EOUT: begin
                if (o_out.ready) begin
                    if (r_k == rdvu_pkg::t_emit_cnt'(rdvu_pkg::EMIT_LEN - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_changed <= 1'b0;
            r_k       <= '0;
            r_node_id <= '0;
        end else begin
            r_state   <= n_state;
            r_changed <= n_changed;
            r_k       <= n_k;
            if (i_cfg_we) begin
                r_node_id <= i_cfg_data;
            end
        end
    end

    // Element payload capture; the own entry of this node itself is never updated.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_dst  <= in_idx;
            r_dist <= i_in.distance;
            r_last <= i_in.last_element;
            r_upd  <= dst_ok && (i_in.dest_index != r_node_id);
        end
    end

    // The memory read register holds the word steady while the sink stalls.
    assign o_out.valid        = (r_state == S_EOUT);
    assign o_out.out_index    = rdvu_pkg::t_node'(r_k);
    assign o_out.out_distance = own_rd;
    assign o_out.out_last     = (r_k == rdvu_pkg::t_emit_cnt'(rdvu_pkg::EMIT_LEN - 1));

endmodule
